// ===== rtl/core/psch_pkg.sv =====
// Shared types and constants of the priority thread scheduler.
// Used by psch_cell and priority_thread_scheduler; depends on nothing.
package psch_pkg;

  localparam int PRIO_W = 8;
  localparam int ID_W   = 16;
  localparam int TIME_W = 32;
  localparam int IN_W   = 64;
  localparam int OUT_W  = 80;

  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_SCHED     = 3'd1,
    MODE_ADD       = 3'd2,
    MODE_KILL_ID   = 3'd3,
    MODE_KILL_SELF = 3'd4,
    MODE_SLEEP     = 3'd5,
    MODE_BLOCK     = 3'd6,
    MODE_NOP       = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LIMIT   = 2'd1,
    ST_LAST    = 2'd2,
    ST_NO_SUCH = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_EXEC,
    FSM_RESP
  } fsm_t;

  typedef enum logic [2:0] {
    CK_NONE,
    CK_TICK,
    CK_ADD,
    CK_KILL,
    CK_SLEEP,
    CK_BLOCK
  } cmd_kind_t;

  // write broadcast to the cells; targeted kinds act on one slot only
  typedef struct packed {
    cmd_kind_t          kind;
    logic [TIME_W-1:0]  wake;
    logic [PRIO_W-1:0]  prio;
    logic [ID_W-1:0]    id;
    logic               bflag;
  } cell_cmd_t;

endpackage

// ===== rtl/core/psch_cell.sv =====
// One thread slot: flags, priority, wake time and id, plus one stage of the
// search chain. Depends on psch_pkg.
module psch_cell #(
  parameter int N   = 16,
  parameter int SW  = 4,
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  psch_pkg::cell_cmd_t             cmd,
  input  logic [SW-1:0]                   cmd_slot,
  input  psch_pkg::mode_t                 scan_mode,
  input  logic [psch_pkg::ID_W-1:0]       scan_id,
  input  logic [SW-1:0]                   cur,
  input  logic                            cin_found,
  input  logic [psch_pkg::PRIO_W+SW-1:0]  cin_key,
  input  logic [SW-1:0]                   cin_slot,
  output logic                            cout_found,
  output logic [psch_pkg::PRIO_W+SW-1:0]  cout_key,
  output logic [SW-1:0]                   cout_slot,
  output logic                            alive,
  output logic [psch_pkg::ID_W-1:0]       id
);
  import psch_pkg::*;

  localparam logic [SW-1:0] IDX_V = SW'(IDX);

  logic               alive_r, blocked_r, asleep_r;
  logic [PRIO_W-1:0]  prio_r;
  logic [TIME_W-1:0]  wake_r;
  logic [ID_W-1:0]    id_r;
  logic               found_r;
  logic [PRIO_W+SW-1:0] key_r;
  logic [SW-1:0]      slot_r;

  logic               hit;
  logic               elig;
  logic [SW:0]        diff;
  logic [SW-1:0]      rank;
  logic [PRIO_W-1:0]  kprio;
  logic [PRIO_W+SW-1:0] key;
  logic               take;

  assign hit = (cmd_slot == IDX_V);

  // search key: priority then distance in wrapped scan order (slot index for add)
  always_comb begin
    elig  = 1'b0;
    kprio = '0;
    diff  = {1'b0, IDX_V} - {1'b0, cur};
    case (scan_mode)
      MODE_SCHED: begin
        elig  = alive_r && !blocked_r && !asleep_r;
        kprio = prio_r;
        diff  = {1'b0, IDX_V} - {1'b0, cur} - {{SW{1'b0}}, 1'b1};
      end
      MODE_KILL_ID: elig = alive_r && (id_r == scan_id);
      MODE_ADD:     elig = !alive_r;
      default:      elig = 1'b0;
    endcase
    if (diff[SW]) diff = diff + (SW+1)'(N);
    rank = (scan_mode == MODE_ADD) ? IDX_V : diff[SW-1:0];
    key  = {kprio, rank};
    take = elig && (!cin_found || key < cin_key);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= take || cin_found;
    end
    key_r  <= take ? key : cin_key;
    slot_r <= take ? IDX_V : cin_slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r   <= 1'b0;
      blocked_r <= 1'b0;
      asleep_r  <= 1'b0;
    end else begin
      case (cmd.kind)
        CK_TICK: begin
          if (alive_r && asleep_r && wake_r == cmd.wake) asleep_r <= 1'b0;
        end
        CK_ADD: begin
          if (hit) begin
            alive_r   <= 1'b1;
            blocked_r <= 1'b0;
            asleep_r  <= 1'b0;
          end
        end
        CK_KILL: begin
          if (hit) begin
            alive_r   <= 1'b0;
            blocked_r <= 1'b0;
          end
        end
        CK_SLEEP: if (hit) asleep_r <= 1'b1;
        CK_BLOCK: if (hit) blocked_r <= cmd.bflag;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hit && cmd.kind == CK_ADD) begin
      prio_r <= cmd.prio;
      id_r   <= cmd.id;
      wake_r <= '0;
    end else if (hit && cmd.kind == CK_SLEEP) begin
      wake_r <= cmd.wake;
    end
  end

  assign cout_found = found_r;
  assign cout_key   = key_r;
  assign cout_slot  = slot_r;
  assign alive      = alive_r;
  assign id         = id_r;

endmodule

// ===== rtl/core/priority_thread_scheduler.sv =====
// Top level of the priority thread scheduler: command sequencer, system
// time and counters, and a chain of MAX_SLOTS slot cells. Depends on
// psch_pkg and psch_cell.
//
//   channel  ports        dir  payload
//   command  in_t*        in   tuser: mode; tdata: priority_req, duration, thread_id,
//                              slot, block_flag
//   result   out_t*       out  status, running_slot, running_id, thread_count,
//                              time_now, new_id
//
// Schedule, add and kill by id walk the cell chain in the scan state before
// execute and response; other commands go from idle straight to execute. The search carry moves one cell a cycle.
// Synchronous active-low reset empties the table; no clearing pass.
// One word at a time; a new command is taken while a result waits, and the
// block holds in its response state while an earlier result waits and out_tready stays low.
module priority_thread_scheduler #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // mode[2:0]
  input  logic [2:0]                  in_tuser,
  // priority_req[7:0] duration[39:8] thread_id[55:40] slot[59:56]
  // block_flag[60] zero[63:61]
  input  logic [psch_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status[1:0] running_slot[5:2] running_id[21:6] thread_count[26:22]
  // time_now[58:27] new_id[74:59] zero[79:75]
  output logic [psch_pkg::OUT_W-1:0]  out_tdata
);
  import psch_pkg::*;

  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int KW = PRIO_W + SW;

  fsm_t               state_r, state_nxt;
  logic [SW-1:0]      cnt_r, cnt_nxt;
  mode_t              mode_r;
  logic [PRIO_W-1:0]  prio_r;
  logic [ID_W-1:0]    tid_r;
  logic [3:0]         slot_r;
  logic               bflag_r;
  logic [TIME_W-1:0]  arg_r;
  logic [SW-1:0]      cur_r, cur_nxt;
  logic [TIME_W-1:0]  tick_r, tick_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [ID_W-1:0]    idc_r, idc_nxt;
  status_t            status_r, status_nxt;
  logic [ID_W-1:0]    newid_r, newid_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]   out_tdata_r, out_tdata_nxt;

  logic               accept;
  mode_t              in_mode;
  cell_cmd_t          cmd;
  logic [SW-1:0]      cmd_slot;

  logic [MAX_SLOTS-1:0]  alive_v;
  logic [ID_W-1:0]       id_a    [MAX_SLOTS];
  logic [MAX_SLOTS:0]    c_found;
  logic [KW-1:0]         c_key   [MAX_SLOTS+1];
  logic [SW-1:0]         c_slot  [MAX_SLOTS+1];

  assign in_tready = (state_r == FSM_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_mode   = mode_t'(in_tuser);

  assign c_found[0] = 1'b0;
  assign c_key[0]   = '0;
  assign c_slot[0]  = '0;

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    psch_cell #(.N(MAX_SLOTS), .SW(SW), .IDX(g)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .cmd_slot   (cmd_slot),
      .scan_mode  (mode_r),
      .scan_id    (tid_r),
      .cur        (cur_r),
      .cin_found  (c_found[g]),
      .cin_key    (c_key[g]),
      .cin_slot   (c_slot[g]),
      .cout_found (c_found[g+1]),
      .cout_key   (c_key[g+1]),
      .cout_slot  (c_slot[g+1]),
      .alive      (alive_v[g]),
      .id         (id_a[g])
    );
  end

  // command fields; time argument is the next tick or the wake time
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      prio_r  <= in_tdata[7:0];
      tid_r   <= in_tdata[55:40];
      slot_r  <= in_tdata[59:56];
      bflag_r <= in_tdata[60];
      arg_r   <= tick_r + ((in_mode == MODE_TICK) ? TIME_W'(1) : in_tdata[39:8]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FSM_IDLE;
      cnt_r        <= '0;
      cur_r        <= '0;
      tick_r       <= '0;
      count_r      <= '0;
      idc_r        <= '0;
      status_r     <= ST_OK;
      newid_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      cur_r        <= cur_nxt;
      tick_r       <= tick_nxt;
      count_r      <= count_nxt;
      idc_r        <= idc_nxt;
      status_r     <= status_nxt;
      newid_r      <= newid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    out_tdata_r <= out_tdata_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cur_nxt        = cur_r;
    tick_nxt       = tick_r;
    count_nxt      = count_r;
    idc_nxt        = idc_r;
    status_nxt     = status_r;
    newid_nxt      = newid_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    cmd            = '{kind: CK_NONE, wake: arg_r, prio: prio_r, id: idc_r, bflag: bflag_r};
    cmd_slot       = cur_r;
    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          if (in_mode == MODE_SCHED || in_mode == MODE_ADD || in_mode == MODE_KILL_ID)
            state_nxt = FSM_SCAN;
          else
            state_nxt = FSM_EXEC;
        end
      end
      FSM_SCAN: begin
        if (cnt_r == SW'(MAX_SLOTS - 1)) state_nxt = FSM_EXEC;
        else cnt_nxt = cnt_r + SW'(1);
      end
      FSM_EXEC: begin
        status_nxt = ST_OK;
        newid_nxt  = '0;
        state_nxt  = FSM_RESP;
        case (mode_r)
          MODE_TICK: begin
            tick_nxt = arg_r;
            cmd.kind = CK_TICK;
          end
          MODE_SCHED: if (c_found[MAX_SLOTS]) cur_nxt = c_slot[MAX_SLOTS];
          MODE_ADD: begin
            if (count_r == CW'(MAX_SLOTS) || !c_found[MAX_SLOTS]) begin
              status_nxt = ST_LIMIT;
            end else begin
              cmd.kind  = CK_ADD;
              cmd_slot  = c_slot[MAX_SLOTS];
              newid_nxt = idc_r;
              idc_nxt   = idc_r + ID_W'(1);
              count_nxt = count_r + CW'(1);
            end
          end
          MODE_KILL_ID: begin
            if (count_r == CW'(1)) begin
              status_nxt = ST_LAST;
            end else if (!c_found[MAX_SLOTS]) begin
              status_nxt = ST_NO_SUCH;
            end else begin
              cmd.kind  = CK_KILL;
              cmd_slot  = c_slot[MAX_SLOTS];
              count_nxt = count_r - CW'(1);
            end
          end
          MODE_KILL_SELF: begin
            if (count_r == CW'(1)) begin
              status_nxt = ST_LAST;
            end else if (!alive_v[cur_r]) begin
              status_nxt = ST_NO_SUCH;
            end else begin
              cmd.kind  = CK_KILL;
              count_nxt = count_r - CW'(1);
            end
          end
          MODE_SLEEP: cmd.kind = CK_SLEEP;
          MODE_BLOCK: begin
            if (32'(slot_r) < MAX_SLOTS) begin
              cmd.kind = CK_BLOCK;
              cmd_slot = SW'(slot_r);
            end
          end
          default: ;
        endcase
      end
      FSM_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {5'd0, newid_r, tick_r, 5'(count_r),
                            alive_v[cur_r] ? id_a[cur_r] : ID_W'(0),
                            4'(cur_r), status_r};
          state_nxt      = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(alive_v) == int'(count_r))
    else $error("thread count differs from alive slots");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while one is in flight");

  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cur_r) < MAX_SLOTS)
    else $error("current slot out of range");

endmodule

// ===== tb/tb.sv =====
// Testbench for priority_thread_scheduler: drives command words with random idling,
// predicts each result with its own scheduler table, and checks every result word.
// Depends on psch_pkg and the scheduler RTL.
module tb;
  import psch_pkg::*;

  localparam int SLOTS = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  run_slot;
    logic [15:0] run_id;
    logic [4:0]  count;
    logic [31:0] now;
    logic [15:0] new_id;
  } result_t;

  class sched_board;
    bit          alive[SLOTS];
    bit          blocked[SLOTS];
    bit          asleep[SLOTS];
    logic [7:0]  prio[SLOTS];
    logic [31:0] wake[SLOTS];
    logic [15:0] ids[SLOTS];
    logic [3:0]  cur;
    logic [31:0] ticks;
    logic [4:0]  count;
    logic [15:0] next_id;
    result_t     pending[$];
    int          errors;

    function new();
      cur = '0; ticks = '0; count = '0; next_id = '0; errors = 0;
    endfunction

    function void note_command(mode_t m, logic [63:0] w);
      logic [3:0]  s;
      int          best_p;
      logic [3:0]  best;
      result_t     r;
      bit          done;
      r = '0;
      done = 0;
      case (m)
        MODE_TICK: begin
          ticks++;
          for (int i = 0; i < SLOTS; i++)
            if (alive[i] && asleep[i] && wake[i] == ticks) asleep[i] = 0;
        end
        MODE_SCHED: begin
          best_p = 256;
          best = cur;
          s = cur + 4'd1;
          for (int n = 0; n < SLOTS; n++) begin
            if (alive[s] && !blocked[s] && !asleep[s] && prio[s] < best_p) begin
              best_p = prio[s];
              best = s;
            end
            s++;
          end
          cur = best;
        end
        MODE_ADD: begin
          r.status = ST_LIMIT;
          if (count < SLOTS)
            for (int i = 0; i < SLOTS && !done; i++)
              if (!alive[i]) begin
                prio[i] = w[7:0];
                alive[i] = 1; asleep[i] = 0; blocked[i] = 0; wake[i] = 0;
                ids[i] = next_id;
                r.new_id = next_id;
                next_id++;
                count++;
                r.status = ST_OK;
                done = 1;
              end
        end
        MODE_KILL_ID: begin
          if (count == 1) r.status = ST_LAST;
          else begin
            r.status = ST_NO_SUCH;
            s = cur;
            for (int n = 0; n < SLOTS && !done; n++) begin
              if (alive[s] && ids[s] == w[55:40]) begin
                alive[s] = 0; blocked[s] = 0; count--;
                r.status = ST_OK;
                done = 1;
              end
              s++;
            end
          end
        end
        MODE_KILL_SELF: begin
          if (count == 1) r.status = ST_LAST;
          else if (!alive[cur]) r.status = ST_NO_SUCH;
          else begin
            alive[cur] = 0; blocked[cur] = 0; count--;
          end
        end
        MODE_SLEEP: begin
          wake[cur] = ticks + w[39:8];
          asleep[cur] = 1;
        end
        MODE_BLOCK: blocked[w[59:56]] = w[60];
        default: ;
      endcase
      r.run_slot = cur;
      r.run_id = alive[cur] ? ids[cur] : 16'd0;
      r.count = count;
      r.now = ticks;
      pending.push_back(r);
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      errors++;
    endtask

    task automatic check_result(logic [79:0] d);
      result_t g, e;
      g.status = d[1:0]; g.run_slot = d[5:2]; g.run_id = d[21:6];
      g.count = d[26:22]; g.now = d[58:27]; g.new_id = d[74:59];
      if (pending.size() == 0) begin
        report("unexpected word", d[31:0], 32'd0);
        return;
      end
      e = pending.pop_front();
      if (g.status !== e.status) report("status", 32'(g.status), 32'(e.status));
      if (g.run_slot !== e.run_slot) report("running_slot", 32'(g.run_slot), 32'(e.run_slot));
      if (g.run_id !== e.run_id) report("running_id", 32'(g.run_id), 32'(e.run_id));
      if (g.count !== e.count) report("thread_count", 32'(g.count), 32'(e.count));
      if (g.now !== e.now) report("time_now", g.now, e.now);
      if (g.new_id !== e.new_id) report("new_id", 32'(g.new_id), 32'(e.new_id));
      if (d[79:75] !== 5'd0) report("pad bits", 32'(d[79:75]), 32'd0);
    endtask
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, out_tvalid, out_tready;
  logic [2:0]  in_tuser;
  logic [63:0] in_tdata;
  logic [79:0] out_tdata;
  sched_board  board;
  int          send_idle, recv_stall;
  longint      cycles;

  priority_thread_scheduler #(.MAX_SLOTS(SLOTS)) u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [63:0] pack_cmd(logic [7:0] p, logic [31:0] dur,
                                           logic [15:0] id, logic [3:0] sl, logic bf);
    return {3'd0, bf, sl, id, dur, p};
  endfunction

  // inputs change only at the falling edge, so blocking updates are race free
  task automatic send(mode_t m, logic [63:0] w);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    in_tvalid = 1;
    in_tuser = m;
    in_tdata = w;
    do @(posedge clk); while (!in_tready);
    board.note_command(m, w);
    @(negedge clk);
    in_tvalid = 0;
  endtask

  task automatic send_mode(mode_t m);
    send(m, pack_cmd(8'($urandom), $urandom, 16'($urandom), 4'($urandom), 1'($urandom)));
  endtask

  // well-formed mix weighted toward table churn; ids aimed at live threads mostly
  task automatic send_random();
    int    k;
    mode_t m;
    logic [15:0] id;
    logic [31:0] dur;
    logic [7:0]  p;
    k = $urandom_range(99);
    m = k < 25 ? MODE_TICK : k < 45 ? MODE_SCHED : k < 60 ? MODE_ADD :
        k < 70 ? MODE_KILL_ID : k < 77 ? MODE_KILL_SELF : k < 85 ? MODE_SLEEP :
        k < 98 ? MODE_BLOCK : MODE_NOP;
    id = $urandom_range(3) == 0 ? 16'($urandom) : board.next_id - 16'($urandom_range(20));
    dur = $urandom_range(4) == 0 ? $urandom : $urandom_range(6);
    p = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom);
    send(m, pack_cmd(p, dur, id, 4'($urandom), 1'($urandom)));
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    board = new();
    cycles = 0;
    send_idle = 0; recv_stall = 0;
    rst_n = 0; in_tvalid = 0; in_tuser = '0; in_tdata = '0; out_tready = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: empty-table kills, full table, last thread, wraps, extremes
    send(MODE_KILL_SELF, pack_cmd(0, 0, 0, 0, 0));
    send(MODE_KILL_ID, pack_cmd(0, 0, 16'hffff, 0, 0));
    send(MODE_SCHED, pack_cmd(0, 0, 0, 0, 0));
    send(MODE_SLEEP, pack_cmd(0, 32'hffffffff, 0, 0, 0));
    send(MODE_ADD, pack_cmd(8'hff, 0, 0, 0, 0));
    send(MODE_KILL_SELF, pack_cmd(0, 0, 0, 0, 0));
    send(MODE_KILL_ID, pack_cmd(0, 0, 0, 0, 0));
    for (int i = 0; i < 16; i++) send(MODE_ADD, pack_cmd(8'(i * 17), 0, 0, 0, 0));
    send(MODE_BLOCK, pack_cmd(0, 0, 0, 4'hf, 1));
    send(MODE_SCHED, pack_cmd(0, 0, 0, 0, 0));
    send(MODE_SLEEP, pack_cmd(0, 0, 0, 0, 0));
    send(MODE_TICK, pack_cmd(0, 0, 0, 0, 0));
    send(MODE_NOP, pack_cmd(8'hff, 32'hffffffff, 16'hffff, 4'hf, 1));
    send(MODE_KILL_ID, pack_cmd(0, 0, 16'd5, 0, 0));
    send(MODE_BLOCK, pack_cmd(0, 0, 0, 4'hf, 0));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 83 : 13) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 83 : 13) : 0;
      for (int n = 0; n < 155; n++) begin
        if (n == 90) drain();
        if (n % 60 == 59) repeat ($urandom_range(30)) send_mode(MODE_TICK);
        send_random();
      end
    end
    send_idle = 0; recv_stall = 0;
    drain();
    if (board.errors == 0 && board.pending.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
